### rtl/itaf_pkg.sv
// Shared types, codes and character helpers of the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
package itaf_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] RecipTen = 32'hCCCCCCCD;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChX = 8'h78;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEX  = 3'd2,
    CMD_PTRL = 3'd3,
    CMD_PTRU = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DEC,
    KIND_HEX,
    KIND_NIL
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_PFX,
    BK_DIG,
    BK_NIL
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic        upper;
    logic        prefix;
    logic [4:0]  ndig;
    logic [63:0] value;
  } job_t;

  typedef struct packed {
    back_state_t state;
    logic [4:0]  ndig;
  } back_stat_t;

  function automatic logic [7:0] nil_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6C;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {4'd0, nib};
    end else begin
      c = (upper ? ChUpA : ChLowA) + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

### rtl/integer_to_ascii_formatter_core.sv
// Channel  Dir  Beat content
// s_axis   in   tuser[2:0] command, tdata[63:0] value
// m_axis   out  tdata[7:0] character, tlast last character of the text
//
// Top level of the integer to ASCII formatter; depends on itaf_pkg and the
// itaf_front, itaf_queue and itaf_back modules.
// A value is popped from the queue, then for decimal the divide-by-ten loop
// produces its digits (up to 10), then its characters (up to 18) go out through
// the output register, which holds while the receiver is not ready.
// The two-entry queue keeps taking values while the back end works or stalls, until it is full.
// Reset is synchronous and clears the queue, sequencer and output valid.
// Unused command codes are taken and produce no characters.
module integer_to_ascii_formatter_core
  import itaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast
);

  logic       job_ok;
  job_t       job;
  logic       full;
  logic       push;
  logic       pop;
  logic       avail;
  job_t       head;
  logic [1:0] count;
  back_stat_t stat;

  assign s_tready = !full;
  assign push     = s_tvalid && !full && job_ok;

  itaf_front u_front (
    .command (s_tuser),
    .value   (s_tdata),
    .job_ok  (job_ok),
    .job     (job)
  );

  itaf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head),
    .count    (count)
  );

  itaf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .stat     (stat)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QueueDepth))
    else $error("job queue count out of range");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail && stat.state == BK_IDLE)
    else $error("pop from empty queue or busy sequencer");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    stat.state == BK_DIG |-> stat.ndig != 5'd0 && stat.ndig <= 5'd16)
    else $error("digit count out of range while emitting");

  a_conv_depth: assert property (@(posedge clk) disable iff (rst)
    stat.state == BK_CONV |-> stat.ndig < 5'd10)
    else $error("decimal digit stack overflow");

endmodule

### rtl/itaf_front.sv
// Front end: decodes the format command, folds the sign and counts hex digits.
// Depends on itaf_pkg.
module itaf_front
  import itaf_pkg::*;
(
  input  logic [2:0]  command,
  input  logic [63:0] value,
  output logic        job_ok,
  output job_t        job
);

  logic [31:0] low;
  logic [4:0]  hex_len;

  assign low = value[31:0];

  // Highest nonzero nibble sets the digit count; zero still gives one digit.
  always_comb begin
    hex_len = 5'd1;
    for (int i = 0; i < 16; i++) begin
      if (value[4*i +: 4] != 4'd0) begin
        hex_len = 5'(i + 1);
      end
    end
  end

  always_comb begin
    job_ok     = 1'b1;
    job.kind   = KIND_DEC;
    job.neg    = 1'b0;
    job.upper  = 1'b0;
    job.prefix = 1'b0;
    job.ndig   = hex_len;
    job.value  = {32'd0, low};
    unique case (command)
      CMD_SDEC: begin
        job.neg   = low[31];
        job.value = {32'd0, (low[31] ? (32'd0 - low) : low)};
      end
      CMD_UDEC: begin
        job.neg = 1'b0;
      end
      CMD_HEX: begin
        job.kind  = KIND_HEX;
        job.value = value;
      end
      CMD_PTRL, CMD_PTRU: begin
        job.kind   = (value == 64'd0) ? KIND_NIL : KIND_HEX;
        job.upper  = (command == CMD_PTRU);
        job.prefix = 1'b1;
        job.value  = value;
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
  end

endmodule

### rtl/itaf_queue.sv
// Two-entry job queue between the front end and the character sequencer.
// Depends on itaf_pkg.
module itaf_queue
  import itaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  job_t       push_job,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output job_t       head,
  output logic [1:0] count
);

  job_t slot [QueueDepth];
  logic wr_ptr;
  logic rd_ptr;

  assign full  = (count == 2'(QueueDepth));
  assign avail = (count != 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/itaf_back.sv
// Back end: converts one job to characters and drives the output register.
// Decimal digits come from a reciprocal divide by ten, one digit per cycle.
// Depends on itaf_pkg.
module itaf_back
  import itaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  job_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output back_stat_t stat
);

  back_state_t state, state_next;

  job_t        cur;
  logic [31:0] x;
  logic [4:0]  n;
  logic [2:0]  pos;
  logic [3:0]  stack [10];

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [4:0]  nm1;
  logic [7:0]  dig_ch;
  logic        free;
  logic        emit;
  logic [7:0]  ch;
  logic        lst;

  assign prod = x * RecipTen;
  assign quo  = {3'd0, prod[63:35]};
  assign rem  = x - ((quo << 3) + (quo << 1));
  assign nm1  = n - 5'd1;
  assign free = !m_tvalid || m_tready;

  assign dig_ch = (cur.kind == KIND_DEC) ? (ChZero + {4'd0, stack[nm1[3:0]]})
                                         : hex_char(cur.value[4*nm1[3:0] +: 4], cur.upper);

  assign stat.state = state;
  assign stat.ndig  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    ch         = ChZero;
    lst        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_DEC: state_next = BK_CONV;
            KIND_HEX: state_next = head.prefix ? BK_PFX : BK_DIG;
            default:  state_next = BK_NIL;
          endcase
        end
      end
      BK_CONV: begin
        if (quo == 32'd0) begin
          state_next = cur.neg ? BK_PFX : BK_DIG;
        end
      end
      BK_PFX: begin
        if (free) begin
          emit = 1'b1;
          if (cur.kind == KIND_DEC) begin
            ch         = ChMinus;
            state_next = BK_DIG;
          end else begin
            ch = (pos == 3'd0) ? ChZero : ChX;
            if (pos == 3'd1) begin
              state_next = BK_DIG;
            end
          end
        end
      end
      BK_DIG: begin
        if (free) begin
          emit = 1'b1;
          ch   = dig_ch;
          lst  = (n == 5'd1);
          if (n == 5'd1) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_NIL: begin
        if (free) begin
          emit = 1'b1;
          ch   = nil_char(pos);
          lst  = (pos == 3'd4);
          if (pos == 3'd4) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Job registers and digit stack.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      x   <= head.value[31:0];
      n   <= (head.kind == KIND_DEC) ? 5'd0 : head.ndig;
      pos <= 3'd0;
    end else if (state == BK_CONV) begin
      stack[n[3:0]] <= rem[3:0];
      n             <= n + 5'd1;
      x             <= quo;
    end else if (emit) begin
      if (state == BK_DIG) begin
        n <= nm1;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // Output register: load on a free slot, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= ch;
      m_tlast <= lst;
    end
  end

endmodule

### sim/tb_integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_formatter_core: values and format commands go in
// on the slave stream, predicted ASCII text is compared beat by beat on the master stream.
// Depends on itaf_pkg and the formatter RTL.
module tb_integer_to_ascii_formatter_core;
  import itaf_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomValues = 178;
  localparam int unsigned HoldCycles = 160;

  // Expected text of every accepted value, kept as a flat queue of character beats.
  class text_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } char_beat_t;

    char_beat_t  pending_chars[$];
    logic [7:0]  text[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function void add_decimal(logic [31:0] mag);
      logic [7:0] digs[$];
      do begin
        digs.push_front(ChZero + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      foreach (digs[i]) text.push_back(digs[i]);
    endfunction

    function void add_hex(logic [63:0] v, logic upper);
      logic [7:0] digs[$];
      logic [3:0] nib;
      do begin
        nib = v[3:0];
        if (nib < 4'd10) begin
          digs.push_front(ChZero + {4'd0, nib});
        end else begin
          digs.push_front((upper ? ChUpA : ChLowA) + {4'd0, nib} - 8'd10);
        end
        v = v >> 4;
      end while (v != 64'd0);
      foreach (digs[i]) text.push_back(digs[i]);
    endfunction

    function void note_input(logic [2:0] cmd, logic [63:0] value);
      logic [31:0] mag;
      string nil_str;
      char_beat_t b;
      nil_str = "(nil)";
      text.delete();
      case (cmd)
        CMD_SDEC: begin
          mag = value[31:0];
          if (mag[31]) begin
            text.push_back(ChMinus);
            mag = -mag;
          end
          add_decimal(mag);
        end
        CMD_UDEC: add_decimal(value[31:0]);
        CMD_HEX:  add_hex(value, 1'b0);
        CMD_PTRL, CMD_PTRU: begin
          if (value == 64'd0) begin
            for (int i = 0; i < nil_str.len(); i++) text.push_back(nil_str[i]);
          end else begin
            text.push_back(ChZero);
            text.push_back(ChX);
            add_hex(value, cmd == CMD_PTRU);
          end
        end
        default: ;  // unused codes produce no text
      endcase
      foreach (text[i]) begin
        b.ch = text[i];
        b.last = (i == text.size() - 1);
        pending_chars.push_back(b);
      end
    endfunction

    function void check_result(logic [7:0] ch, logic last);
      char_beat_t b;
      checked++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character beat: character %h last %b", ch, last);
        errors++;
        return;
      end
      b = pending_chars.pop_front();
      if (ch !== b.ch) begin
        $error("character: expected %h, actual %h", b.ch, ch);
        errors++;
      end
      if (last !== b.last) begin
        $error("last: expected %b, actual %b", b.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_scoreboard sb = new();

  int unsigned cmd_count[8];
  int unsigned burst_left = 0;
  logic        hold_req = 1'b0;

  always #4 clk = ~clk;

  integer_to_ascii_formatter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Offer one value; open a new burst after a random gap when the current one runs out.
  task automatic offer_value(input logic [2:0] cmd, input logic [63:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tuser  <= cmd;
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, value);
    cmd_count[cmd]++;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: v = 64'd0;
      1: v = 64'($urandom_range(0, 20));
      2: v = v >> $urandom_range(0, 63);
      3: v = {v[63:32], v[31:0] >> $urandom_range(0, 31)};
      4: v = ($urandom_range(0, 1) == 1) ? ~64'd0 >> $urandom_range(0, 63)
                                         : 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: stall pattern drawn at random from four modes; one long hold-off on request.
  always @(posedge clk) begin : receiver
    static int unsigned cyc = 0;
    static int unsigned mode = 0;
    static int unsigned hold_left = 0;
    static bit hold_done = 0;
    if (cyc % 64 == 0) mode = $urandom_range(0, 3);
    cyc++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = HoldCycles - 1;
      m_tready <= 1'b0;
    end else begin
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        2:       m_tready <= (cyc % 3 != 0);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin : watchdog
    static int unsigned idle = 0;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
    else idle++;
    if (idle >= IdleLimit) begin
      $display("timeout: no beat for %0d cycles", idle);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    logic [2:0] cmd;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of each format and the special cases.
    offer_value(CMD_SDEC, 64'd0);
    offer_value(CMD_SDEC, ~64'd0);
    offer_value(CMD_SDEC, 64'h0000_0000_8000_0000);
    offer_value(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
    offer_value(CMD_SDEC, 64'hDEAD_BEEF_0000_0007);
    offer_value(CMD_UDEC, 64'd0);
    offer_value(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
    offer_value(CMD_UDEC, 64'hFFFF_FFFF_8000_0000);
    offer_value(CMD_UDEC, 64'd9);
    offer_value(CMD_UDEC, 64'd10);
    offer_value(CMD_HEX, 64'd0);
    offer_value(CMD_HEX, ~64'd0);
    offer_value(CMD_HEX, 64'd1);
    offer_value(CMD_HEX, 64'h8000_0000_0000_0000);
    offer_value(CMD_PTRL, 64'd0);
    offer_value(CMD_PTRU, 64'd0);
    offer_value(CMD_PTRL, ~64'd0);
    offer_value(CMD_PTRU, 64'h0123_4567_89AB_CDEF);
    offer_value(CMD_PTRU, ~64'd0);
    offer_value(CMD_PTRL, 64'h0000_0000_00AB_CDEF);
    offer_value(3'd5, 64'h1234_5678_9ABC_DEF0);
    offer_value(3'd6, 64'd0);
    offer_value(3'd7, ~64'd0);

    // Random: mostly valid commands, a few unused codes mixed in.
    sent = 0;
    while (sent < RandomValues) begin
      if (sent == 30) hold_req <= 1'b1;
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      offer_value(cmd, pick_value());
      if (cmd <= CMD_PTRU) sent++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered: %0d signed, %0d unsigned, %0d hex, %0d pointer, %0d unused-code values",
             cmd_count[CMD_SDEC], cmd_count[CMD_UDEC], cmd_count[CMD_HEX],
             cmd_count[CMD_PTRL] + cmd_count[CMD_PTRU],
             cmd_count[5] + cmd_count[6] + cmd_count[7]);
    $display("Checked %0d character beats under varied stalls and one long hold-off, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
